/* rtl/stp_pkg.sv */
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and widths for the spin torque projection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stp_pkg;

  localparam int MM_W   = 34;  // unsigned q.30 of m.m
  localparam int MH_W   = 35;  // signed q.16 of m.h
  localparam int D_W    = 37;  // signed q.16 projected field
  localparam int SQ_W   = 74;  // radicand, even width
  localparam int R_W    = SQ_W / 2;
  localparam int REM_W  = R_W + 3;
  localparam int C_W    = R_W + 3;
  localparam int OM_W   = MM_W + 2;
  localparam int CO_W   = C_W + 1 + OM_W;
  localparam int K_W    = 46;
  localparam int KM_W   = K_W + 32;
  localparam int SUM_W  = KM_W - 30 + 1;

  typedef struct packed {
    logic signed [31:0] m_x;
    logic signed [31:0] m_y;
    logic signed [31:0] m_z;
    logic signed [31:0] h_x;
    logic signed [31:0] h_y;
    logic signed [31:0] h_z;
    logic               pinned;
  } stp_in_t;

  typedef struct packed {
    logic signed [31:0] dm_x;
    logic signed [31:0] dm_y;
    logic signed [31:0] dm_z;
  } stp_out_t;

  typedef struct packed {
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
    logic signed [31:0]    m_x;
    logic signed [31:0]    m_y;
    logic signed [31:0]    m_z;
    logic [MM_W-1:0]       mm;
    logic                  pinned;
  } stp_side_t;

endpackage

/* rtl/spin_torque_projection.sv */
// ----------------------------------------------------------------------------
// spin_torque_projection
// Projected spin derivative per site, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one spin site per transaction: m (signed
//   Q1.30), h (signed Q15.16) and a pin flag. out_valid/out_stall/out_data
//   return one derivative vector (signed Q15.16, saturated) per site, in order.
//   The dot products, projection and squared norm come first, then the square
//   root (one root bit per stage), then the split correction multiplies and
//   saturation. Throughput is one site per cycle while no result is stalled.
//   All stages advance together; when a result waits on out_stall the whole
//   pipeline holds and in_stall is raised, so nothing is lost or repeated.
//   A pinned site still takes the full latency and returns the zero vector.
//   Synchronous reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spin_torque_projection import stp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  stp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output stp_out_t out_data
);

  logic            en;
  logic            sq_valid, root_valid;
  logic [SQ_W-1:0] sq;
  logic [R_W-1:0]  root;
  stp_side_t       side_a, side_b;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  stp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .sq_valid (sq_valid),
    .sq       (sq),
    .side     (side_a)
  );

  stp_isqrt u_isqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .sq_valid   (sq_valid),
    .sq         (sq),
    .side_in    (side_a),
    .root_valid (root_valid),
    .root       (root),
    .side_out   (side_b)
  );

  stp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .root_valid (root_valid),
    .root       (root),
    .side       (side_b),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

/* rtl/stp_front.sv */
// ----------------------------------------------------------------------------
// stp_front
// Dot products and projected field d, then the squared norm of d.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_front import stp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  stp_in_t         in_data,
  output logic            sq_valid,
  output logic [SQ_W-1:0] sq,
  output stp_side_t       side
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1
  stp_in_t            s1_r;
  logic signed [63:0] pmm_r [3];
  logic signed [63:0] pmh_r [3];
  // stage 2
  stp_in_t            s2_r;
  logic [MM_W-1:0]    mm2_r;
  logic signed [MH_W-1:0] mh2_r;
  logic signed [65:0] acc_mm, acc_mh;
  // stage 3
  stp_in_t            s3_r;
  logic [MM_W-1:0]    mm3_r;
  logic signed [66:0] pa_r [3];
  logic signed [66:0] pb_r [3];
  // stage 4
  stp_in_t            s4_r;
  logic [MM_W-1:0]    mm4_r;
  logic signed [D_W-1:0] d4_r [3];
  logic signed [67:0] diff [3];
  // stage 5
  stp_in_t            s5_r;
  logic [MM_W-1:0]    mm5_r;
  logic signed [D_W-1:0] d5_r [3];
  logic signed [SQ_W-1:0] dsq_r [3];
  // stage 6
  stp_side_t          side_r;
  logic [SQ_W-1:0]    sq_r;

  always_comb begin
    acc_mm = 66'(pmm_r[0]) + 66'(pmm_r[1]) + 66'(pmm_r[2]);
    acc_mh = 66'(pmh_r[0]) + 66'(pmh_r[1]) + 66'(pmh_r[2]);
    for (int i = 0; i < 3; i++) begin
      diff[i] = 68'(pa_r[i]) - 68'(pb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= in_data;
      pmm_r[0] <= in_data.m_x * in_data.m_x;
      pmm_r[1] <= in_data.m_y * in_data.m_y;
      pmm_r[2] <= in_data.m_z * in_data.m_z;
      pmh_r[0] <= in_data.m_x * in_data.h_x;
      pmh_r[1] <= in_data.m_y * in_data.h_y;
      pmh_r[2] <= in_data.m_z * in_data.h_z;

      s2_r  <= s1_r;
      mm2_r <= acc_mm[63:30];
      mh2_r <= acc_mh[64:30];

      s3_r  <= s2_r;
      mm3_r <= mm2_r;
      pa_r[0] <= $signed({1'b0, mm2_r}) * s2_r.h_x;
      pa_r[1] <= $signed({1'b0, mm2_r}) * s2_r.h_y;
      pa_r[2] <= $signed({1'b0, mm2_r}) * s2_r.h_z;
      pb_r[0] <= mh2_r * s2_r.m_x;
      pb_r[1] <= mh2_r * s2_r.m_y;
      pb_r[2] <= mh2_r * s2_r.m_z;

      s4_r  <= s3_r;
      mm4_r <= mm3_r;
      for (int i = 0; i < 3; i++) begin
        d4_r[i] <= diff[i][66:30];
      end

      s5_r  <= s4_r;
      mm5_r <= mm4_r;
      for (int i = 0; i < 3; i++) begin
        d5_r[i]  <= d4_r[i];
        dsq_r[i] <= d4_r[i] * d4_r[i];
      end

      sq_r          <= dsq_r[0] + dsq_r[1] + dsq_r[2];
      side_r.d_x    <= d5_r[0];
      side_r.d_y    <= d5_r[1];
      side_r.d_z    <= d5_r[2];
      side_r.m_x    <= s5_r.m_x;
      side_r.m_y    <= s5_r.m_y;
      side_r.m_z    <= s5_r.m_z;
      side_r.mm     <= mm5_r;
      side_r.pinned <= s5_r.pinned;
    end
  end

  assign sq_valid = v6_r;
  assign sq       = sq_r;
  assign side     = side_r;

endmodule

/* rtl/stp_isqrt.sv */
// ----------------------------------------------------------------------------
// stp_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_isqrt import stp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            sq_valid,
  input  logic [SQ_W-1:0] sq,
  input  stp_side_t       side_in,
  output logic            root_valid,
  output logic [R_W-1:0]  root,
  output stp_side_t       side_out
);

  logic             v_r    [R_W];
  logic [SQ_W-1:0]  rad_r  [R_W];
  logic [REM_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]   root_r [R_W];
  stp_side_t        side_r [R_W];

  logic             v_p    [R_W];
  logic [SQ_W-1:0]  rad_p  [R_W];
  logic [REM_W-1:0] rem_p  [R_W];
  logic [R_W-1:0]   root_p [R_W];
  stp_side_t        side_p [R_W];

  genvar k;
  generate
    for (k = 0; k < R_W; k++) begin : g_stage
      logic [REM_W-1:0] rem_sh, trial;

      if (k == 0) begin : g_first
        assign v_p[k]    = sq_valid;
        assign rad_p[k]  = sq;
        assign rem_p[k]  = '0;
        assign root_p[k] = '0;
        assign side_p[k] = side_in;
      end else begin : g_next
        assign v_p[k]    = v_r[k-1];
        assign rad_p[k]  = rad_r[k-1];
        assign rem_p[k]  = rem_r[k-1];
        assign root_p[k] = root_r[k-1];
        assign side_p[k] = side_r[k-1];
      end

      assign rem_sh = {rem_p[k][REM_W-3:0], rad_p[k][SQ_W-1 -: 2]};
      assign trial  = {1'b0, root_p[k], 2'b01};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_p[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k]  <= {rad_p[k][SQ_W-3:0], 2'b00};
          side_r[k] <= side_p[k];
          if (rem_sh >= trial) begin
            rem_r[k]  <= rem_sh - trial;
            root_r[k] <= {root_p[k][R_W-2:0], 1'b1};
          end else begin
            rem_r[k]  <= rem_sh;
            root_r[k] <= {root_p[k][R_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root_valid = v_r[R_W-1];
  assign root       = root_r[R_W-1];
  assign side_out   = side_r[R_W-1];

endmodule

/* rtl/stp_back.sv */
// ----------------------------------------------------------------------------
// stp_back
// Norm correction 6*|d|*(1-mm)*m, addition to d, output saturation and zero for pinned sites.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_back import stp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           root_valid,
  input  logic [R_W-1:0] root,
  input  stp_side_t      side,
  output logic           out_valid,
  output stp_out_t       out_data
);

  localparam logic signed [OM_W-1:0] Q30_ONE = OM_W'(1) <<< 30;
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(33'sh0_8000_0000);

  // partial product split of the two wide multiplies
  localparam int CL_W = C_W / 2;
  localparam int CP_W = C_W - CL_W + 1 + OM_W;
  localparam int KL_W = K_W / 2;
  localparam int KP_W = KL_W + 1 + 32;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  stp_side_t              s1_r, s2_r, s3_r, s4_r, s5_r;
  logic [C_W-1:0]         c_r;
  logic signed [OM_W-1:0] om_r;
  logic signed [CP_W-1:0] pcl_r, pch_r;
  logic signed [CO_W-1:0] co;
  logic signed [K_W-1:0]  k_r;
  logic signed [31:0]     m3 [3];
  logic signed [KP_W-1:0] pkl_r [3];
  logic signed [KP_W-1:0] pkh_r [3];
  logic signed [KM_W-1:0] km [3];
  logic signed [KM_W-1:0] km_r [3];
  logic signed [SUM_W-1:0] sum [3];
  logic signed [31:0]     sat [3];
  logic signed [D_W-1:0]  d5 [3];
  stp_out_t               out_r;

  assign m3[0] = s3_r.m_x;
  assign m3[1] = s3_r.m_y;
  assign m3[2] = s3_r.m_z;

  assign d5[0] = s5_r.d_x;
  assign d5[1] = s5_r.d_y;
  assign d5[2] = s5_r.d_z;

  always_comb begin
    co = (CO_W'(pch_r) <<< CL_W) + CO_W'(pcl_r);
    for (int i = 0; i < 3; i++) begin
      km[i]  = (KM_W'(pkh_r[i]) <<< KL_W) + KM_W'(pkl_r[i]);
      sum[i] = SUM_W'(d5[i]) + SUM_W'($signed(km_r[i][KM_W-1:30]));
      if (sum[i] > OUT_MAX) begin
        sat[i] = 32'sh7fff_ffff;
      end else if (sum[i] < OUT_MIN) begin
        sat[i] = 32'sh8000_0000;
      end else begin
        sat[i] = sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= root_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= side;
      c_r  <= C_W'(root) * C_W'(6);
      om_r <= Q30_ONE - $signed({2'b00, side.mm});

      s2_r  <= s1_r;
      pcl_r <= $signed({1'b0, c_r[CL_W-1:0]}) * om_r;
      pch_r <= $signed({1'b0, c_r[C_W-1:CL_W]}) * om_r;

      s3_r <= s2_r;
      k_r  <= co[CO_W-2:30];

      s4_r <= s3_r;
      for (int i = 0; i < 3; i++) begin
        pkl_r[i] <= $signed({1'b0, k_r[KL_W-1:0]}) * m3[i];
        pkh_r[i] <= $signed(k_r[K_W-1:KL_W]) * m3[i];
      end

      s5_r <= s4_r;
      for (int i = 0; i < 3; i++) begin
        km_r[i] <= km[i];
      end

      if (s5_r.pinned) begin
        out_r <= '0;
      end else begin
        out_r.dm_x <= sat[0];
        out_r.dm_y <= sat[1];
        out_r.dm_z <= sat[2];
      end
    end
  end

  assign out_valid = v6_r;
  assign out_data  = out_r;

endmodule

/* rtl/stp_checker.sv */
// ----------------------------------------------------------------------------
// stp_checker
// Port level checks for spin_torque_projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_checker import stp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input stp_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input stp_out_t out_data
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed under stall");

  // input only backs up when the output is blocked
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // input backs up whenever the output is blocked
  a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline held");

  // nothing leaves straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spin_torque_projection stp_checker u_stp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
